[src/float32_adder_unit_macros.svh]
// Assertion macros for the float32 adder unit.
`ifndef FLOAT32_ADDER_UNIT_MACROS_SVH
`define FLOAT32_ADDER_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define FAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");
// Next-cycle implication checked outside reset.
`define FAU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`endif

[src/fadd_pkg.sv]
// ----------------------------------------------------------------------------
// fadd_pkg
// Shared widths and constants of the float32 adder unit.
// ----------------------------------------------------------------------------
package fadd_pkg;
	localparam logic [31:0] MaxFinite = 32'h7F7F_FFFF;

	typedef struct packed {
		logic [31:0] operand_a;
		logic [31:0] operand_b;
	} fadd_in_t;

	typedef struct packed {
		logic [31:0] sum_word;
		logic        overflowed;
		logic        underflowed;
	} fadd_out_t;
endpackage

[src/fadd_stream_if.sv]
// ----------------------------------------------------------------------------
// fadd_stream_if
// Valid/ready channel carrying one payload word per transaction.
// ----------------------------------------------------------------------------
interface fadd_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/float32_adder_unit.sv]
// ----------------------------------------------------------------------------
// float32_adder_unit
// Single-precision adder, truncating, with saturate/flush flags.
// ----------------------------------------------------------------------------
// Path: a transaction is registered in stages 1, 2 and 3, then in the stage 4 output register.
// Throughput: one transaction per cycle; the four-stage pipe advances as
// a whole whenever its last stage is empty or is being taken.
// Reset: arst_n clears all stage valid bits; payload registers keep data.
module float32_adder_unit (
	input  logic      clk,
	input  logic      arst_n,
	fadd_stream_if.sink   in_ch,
	fadd_stream_if.source out_ch
);
	import fadd_pkg::*;

	// Stage valid bits and the global advance enable.
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv;

	assign adv          = !v_s4 || out_ch.ready;
	assign in_ch.ready  = adv;
	assign out_ch.valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// ---------------- Stage 1: unpack, order by exponent ----------------
	logic [31:0] a, b;
	logic [7:0]  ea, eb;
	logic        a_ge;
	assign a  = in_ch.data.operand_a;
	assign b  = in_ch.data.operand_b;
	assign ea = a[30:23];
	assign eb = b[30:23];
	assign a_ge = (ea >= eb);

	logic        bypass_s1;   // zero-exponent operand (zero or subnormal): pass the other word through
	logic [31:0] byp_word_s1;
	logic [23:0] big_m_s1, small_m_s1;
	logic        big_sg_s1, small_sg_s1;
	logic [7:0]  d_s1, e_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			bypass_s1   <= (ea == 8'd0) || (eb == 8'd0);
			byp_word_s1 <= (ea == 8'd0) ? b : a;
			big_m_s1    <= a_ge ? {1'b1, a[22:0]} : {1'b1, b[22:0]};
			small_m_s1  <= a_ge ? {1'b1, b[22:0]} : {1'b1, a[22:0]};
			big_sg_s1   <= a_ge ? a[31] : b[31];
			small_sg_s1 <= a_ge ? b[31] : a[31];
			d_s1        <= a_ge ? (ea - eb) : (eb - ea);
			e_s1        <= a_ge ? ea : eb;
		end
	end

	// ---------------- Stage 2: align and add ----------------
	logic [23:0] sh_m;
	logic [24:0] sum_add;
	logic [24:0] mag_c;
	logic        sign_c, zero_c;
	assign sh_m    = (d_s1 >= 8'd24) ? 24'd0 : (small_m_s1 >> d_s1[4:0]);
	assign sum_add = {1'b0, big_m_s1} + {1'b0, sh_m};

	always_comb begin
		mag_c  = sum_add;
		sign_c = big_sg_s1;
		zero_c = 1'b0;
		if (big_sg_s1 != small_sg_s1) begin
			if (big_m_s1 > sh_m) begin
				mag_c = {1'b0, big_m_s1 - sh_m};
			end else if (sh_m > big_m_s1) begin
				mag_c  = {1'b0, sh_m - big_m_s1};
				sign_c = small_sg_s1;
			end else begin
				mag_c  = 25'd0;
				zero_c = 1'b1;
			end
		end
	end

	logic        bypass_s2, zero_s2, sign_s2;
	logic [31:0] byp_word_s2;
	logic [24:0] mag_s2;
	logic [7:0]  e_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			bypass_s2   <= bypass_s1;
			byp_word_s2 <= byp_word_s1;
			zero_s2     <= zero_c;
			sign_s2     <= sign_c;
			mag_s2      <= mag_c;
			e_s2        <= e_s1;
		end
	end

	// ---------------- Stage 3: leading-zero count ----------------
	// Register the carry-out, which stage 4 folds into a right shift; count leading zeros of
	// the 24-bit magnitude otherwise.
	logic [4:0] lz;
	always_comb begin
		lz = 5'd0;
		for (int i = 0; i < 24; i++) begin
			if (mag_s2[i]) lz = 5'(23 - i);
		end
	end

	logic        bypass_s3, zero_s3, sign_s3, carry_s3;
	logic [31:0] byp_word_s3;
	logic [24:0] mag_s3;
	logic [7:0]  e_s3;
	logic [4:0]  lz_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			bypass_s3   <= bypass_s2;
			byp_word_s3 <= byp_word_s2;
			zero_s3     <= zero_s2;
			sign_s3     <= sign_s2;
			carry_s3    <= mag_s2[24];
			mag_s3      <= mag_s2;
			e_s3        <= e_s2;
			lz_s3       <= lz;
		end
	end

	// ---------------- Stage 4: normalize, range check, pack ----------------
	logic [23:0] norm_m;
	logic signed [9:0] e_n;
	fadd_out_t res;
	assign norm_m = carry_s3 ? mag_s3[24:1] : (mag_s3[23:0] << lz_s3);
	assign e_n    = carry_s3 ? $signed({2'b00, e_s3}) + 10'sd1
	                         : $signed({2'b00, e_s3}) - $signed({5'd0, lz_s3});

	always_comb begin
		res.sum_word    = {sign_s3, e_n[7:0], norm_m[22:0]};
		res.overflowed  = 1'b0;
		res.underflowed = 1'b0;
		if (bypass_s3) begin
			res.sum_word = byp_word_s3;
		end else if (zero_s3) begin
			res.sum_word = 32'd0;
		end else if (e_n >= 10'sd255) begin
			res.sum_word   = {sign_s3, 31'd0} | MaxFinite;
			res.overflowed = 1'b1;
		end else if (e_n <= 10'sd0) begin
			res.sum_word    = {sign_s3, 31'd0};
			res.underflowed = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_ch.data <= res;
		end
	end
endmodule

[src/fadd_checker.sv]
// ----------------------------------------------------------------------------
// fadd_checker
// Port-level checks of the float32 adder unit.
// ----------------------------------------------------------------------------
`include "float32_adder_unit_macros.svh"
module fadd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input fadd_pkg::fadd_out_t out_data
);
	// A result never carries both flags.
	`FAU_ASSERT_IMP(a_flags_excl, clk, arst_n, out_valid, !(out_data.overflowed && out_data.underflowed))
	// Overflow always saturates to the largest finite magnitude.
	`FAU_ASSERT_IMP(a_ovf_sat, clk, arst_n, out_valid && out_data.overflowed, out_data.sum_word[30:0] == 31'h7F7F_FFFF)
	// Underflow always yields a signed zero.
	`FAU_ASSERT_IMP(a_unf_zero, clk, arst_n, out_valid && out_data.underflowed, out_data.sum_word[30:0] == 31'd0)
	// A stalled result stays in place.
	`FAU_ASSERT_NXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	// The input side is open whenever the output side is not blocked.
	`FAU_ASSERT_IMP(a_ready, clk, arst_n, out_ready, in_ready)
endmodule

bind float32_adder_unit fadd_checker u_fadd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);
